// File: hw/rtl/sh0_pkg.sv
// ---------------------------------------------------------------------------
// sh0_pkg: shared types and constants for the Struve H0 unit
// Fixed-point constants (Q23.40), polynomial tables and small helper functions
// used by the sequencer and its arithmetic units.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sh0_pkg;

  localparam int MAX_SERIES_TERMS_DEF = 60;
  localparam int MAX_ASYM_TERMS_DEF   = 25;

  typedef logic signed [63:0] q40_t;

  localparam q40_t ONE_Q40          = 64'sh0000_0100_0000_0000;
  localparam q40_t SAT_POS          = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q40_t SAT_NEG          = -SAT_POS;
  localparam q40_t HALF_PI_Q40      = 64'sh0000_0192_1FB5_4443;
  localparam q40_t HALF_PI_HALF_Q40 = HALF_PI_Q40 >>> 1;
  localparam q40_t QUARTER_PI_Q40   = 64'sh0000_00C9_0FDA_A221;
  localparam q40_t TWO_OVER_PI_Q40  = 64'sh0000_00A2_F983_6E4E;
  localparam q40_t EPS_Q64          = 64'sd18446744;

  // Argument thresholds in the Q11.20 input format.
  localparam logic [31:0] X_SERIES_MAX = 32'd20 << 20;
  localparam logic [31:0] X_ASYM_CAP   = 32'd50 << 20;

  // Decimal coefficient m * 1e-10 converted to Q40, rounded.
  function automatic q40_t dec10(input logic [63:0] m);
    logic [63:0] v;
    v = ((m << 30) + 64'd4882812) / 64'd9765625;
    return q40_t'(v);
  endfunction

  localparam q40_t P_COEF [6] = '{
    -dec10(64'd37043), dec10(64'd173565), -dec10(64'd487613),
    dec10(64'd1734300), -dec10(64'd17530620), dec10(64'd3989422793)
  };

  localparam q40_t Q_COEF [6] = '{
    dec10(64'd32312), -dec10(64'd142078), dec10(64'd342468),
    -dec10(64'd869791), dec10(64'd4564324), -dec10(64'd124669441)
  };

  typedef enum logic [5:0] {
    ST_IDLE, ST_INIT,
    ST_SER_U, ST_SER_RU, ST_SER_RUU, ST_SER_CHK, ST_SER_H1, ST_SER_H2,
    ST_ASY_KM, ST_ASY_V, ST_ASY_VV, ST_ASY_R, ST_ASY_CHK,
    ST_ASY_T, ST_ASY_T2, ST_ASY_P, ST_ASY_Q, ST_ASY_QT,
    ST_ASY_N, ST_ASY_NH, ST_ASY_R2,
    ST_SIN_M, ST_SIN_D, ST_COS_M, ST_COS_D, ST_ASY_QUAD,
    ST_ASY_SQ, ST_ASY_W, ST_ASY_PS, ST_ASY_QC, ST_ASY_BY, ST_ASY_G, ST_ASY_H,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic raw;    // keep the exact 128-bit product, no rounding
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic frac;   // rounded Q40 quotient; otherwise plain integer quotient
  } div_req_t;

  function automatic logic [63:0] mag64(input q40_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic q40_t sat_add(input q40_t a, input q40_t b);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    lim = 65'(SAT_POS);
    s = 65'(a) + 65'(b);
    if (s > lim) begin
      return SAT_POS;
    end else if (s < -lim) begin
      return SAT_NEG;
    end
    return s[63:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sh0_mul.sv
// ---------------------------------------------------------------------------
// sh0_mul: multi-cycle Q40 multiplier
// Forms the 128-bit product of two magnitudes from four 32x32 partial
// products, one per cycle, then rounds and saturates to signed Q40.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sh0_mul (
  input  logic             clk,
  input  logic             rst,
  input  sh0_pkg::mul_req_t req,
  input  sh0_pkg::q40_t    a,
  input  sh0_pkg::q40_t    b,
  output logic             done,
  output sh0_pkg::q40_t    res,
  output logic [63:0]      hi,
  output logic [63:0]      lo
);
  import sh0_pkg::*;

  logic [63:0]  ma, mb;
  logic         neg;
  logic [127:0] acc;
  logic [1:0]   step;
  logic         run, fin;
  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  m;

  always_comb begin
    case (step)
      2'd0: begin
        opa = ma[31:0];  opb = mb[31:0];
      end
      2'd1: begin
        opa = ma[31:0];  opb = mb[63:32];
      end
      2'd2: begin
        opa = ma[63:32]; opb = mb[31:0];
      end
      default: begin
        opa = ma[63:32]; opb = mb[63:32];
      end
    endcase
    pp = 64'(opa) * 64'(opb);
    case (step)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    if (|acc[127:103]) begin
      m = 64'(SAT_POS);
    end else begin
      m = {1'b0, acc[102:40]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        step <= 2'd0;
        ma   <= mag64(a);
        mb   <= mag64(b);
        neg  <= a[63] ^ b[63];
        // Seeding with half an LSB makes the final slice round to nearest.
        acc  <= req.raw ? 128'd0 : (128'd1 << 39);
      end else if (run) begin
        acc  <= acc + pp_sh;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        res  <= neg ? -q40_t'(m) : q40_t'(m);
        hi   <= acc[127:64];
        lo   <= acc[63:0];
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sh0_div.sv
// ---------------------------------------------------------------------------
// sh0_div: bit-serial unsigned divider
// Restoring long division, one quotient bit per cycle. Integer mode gives
// n / d in 64 steps; fraction mode gives round(n * 2^40 / d) in 104 steps,
// saturated to the largest positive Q40 value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sh0_div (
  input  logic             clk,
  input  logic             rst,
  input  sh0_pkg::div_req_t req,
  input  logic [63:0]      n,
  input  logic [63:0]      d,
  output logic             done,
  output sh0_pkg::q40_t    q
);
  import sh0_pkg::*;

  logic [103:0] num;
  logic [64:0]  rem;
  logic [63:0]  quo, dd;
  logic         ovf, frac, run, fin;
  logic [6:0]   cnt;
  logic [64:0]  rem_sh;
  logic         ge;
  logic [64:0]  qr;
  logic         rnd;

  always_comb begin
    rem_sh = {rem[63:0], num[103]};
    ge     = rem_sh >= {1'b0, dd};
    rnd    = {rem[63:0], 1'b0} >= {1'b0, dd};
    qr     = {1'b0, quo} + 65'(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        num  <= {n, 40'd0};
        rem  <= '0;
        quo  <= '0;
        ovf  <= 1'b0;
        dd   <= d;
        frac <= req.frac;
        cnt  <= req.frac ? 7'd104 : 7'd64;
      end else if (run) begin
        rem <= ge ? rem_sh - {1'b0, dd} : rem_sh;
        quo <= {quo[62:0], ge};
        ovf <= ovf | quo[63];
        num <= num << 1;
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        if (!frac) begin
          q <= q40_t'(quo);
        end else if (ovf || quo[63] || qr[63]) begin
          q <= SAT_POS;
        end else begin
          q <= q40_t'(qr[63:0]);
        end
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sh0_sqrt.sv
// ---------------------------------------------------------------------------
// sh0_sqrt: iterative integer square root
// Classic digit-by-digit root of a 64-bit value, 32 steps, rounded to nearest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sh0_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [63:0] root
);

  logic [63:0] vv, res, bitv, trial;
  logic [4:0]  cnt;
  logic        run, fin;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        vv   <= v;
        res  <= '0;
        bitv <= 64'd1 << 62;
        cnt  <= 5'd0;
      end else if (run) begin
        if (vv >= trial) begin
          vv  <= vv - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        root <= (vv > res) ? res + 64'd1 : res;
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/struve_h0_function_unit.sv
// ---------------------------------------------------------------------------
// struve_h0_function_unit: Struve function H0(x) evaluator
// Sequencer and datapath registers around a shared multiplier, a bit-serial
// divider and an iterative square root unit.
// ---------------------------------------------------------------------------
//
//  Channel  | Ports                 | Handshake
//  ---------+-----------------------+------------------------------------------
//  command  | start, x_arg, busy    | taken at a clock edge with start & !busy
//  result   | done, h0_value        | done pulses one cycle; no back-pressure
//
// Each transaction takes a data-dependent number of cycles. A power series
// term costs a 64-step integer division plus three multiplications. Large
// arguments spend most of each asymptotic term in a 104-step fractional
// division, at most 25 terms, plus the polynomials, sin/cos, square root
// and final scaling. The bit-serial divider dominates the run time. Reset
// is synchronous and returns the sequencer to idle; no item is in flight
// afterwards. The unit accepts a new command in the cycle in which done is
// shown.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module struve_h0_function_unit #(
  parameter int MAX_SERIES_TERMS     = sh0_pkg::MAX_SERIES_TERMS_DEF,
  parameter int MAX_ASYMPTOTIC_TERMS = sh0_pkg::MAX_ASYM_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x_arg,
  output logic        busy,
  output logic        done,
  output logic signed [31:0] h0_value
);
  import sh0_pkg::*;

  localparam int KMAX = (MAX_SERIES_TERMS > MAX_ASYMPTOTIC_TERMS) ?
                        MAX_SERIES_TERMS : MAX_ASYMPTOTIC_TERMS;
  localparam int KW   = $clog2(KMAX + 1);

  state_t state, state_next;
  logic   launched, launched_next, is_op, issue;

  // Working registers, all Q40 unless noted.
  logic        neg;
  logic [31:0] xa;       // |x| in Q20
  q40_t        x, s, r, u, tmp, term, sh, t, t2, p, q, sn, cs, w, by0, acc2, ang, rt;
  logic [1:0]  nq;       // quadrant of the reduced angle
  logic [KW-1:0] k, km;
  logic [2:0]  ci;

  // Shared unit connections.
  mul_req_t    mul_req;
  div_req_t    div_req;
  logic        sq_start;
  q40_t        mul_a, mul_b, mul_res, div_q;
  logic [63:0] mul_hi, mul_lo, div_n, div_d, sq_root;
  logic        mul_done, div_done, sq_done, op_done;

  logic [4:0]  tk;
  logic [9:0]  sin_div, cos_div;
  logic [32:0] km_sum;
  logic [11:0] km_raw;
  logic        term_small;
  q40_t        ang_off, ang_rem;

  sh0_mul u_mul (
    .clk(clk), .rst(rst), .req(mul_req), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res), .hi(mul_hi), .lo(mul_lo)
  );

  sh0_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .n(div_n), .d(div_d),
    .done(div_done), .q(div_q)
  );

  sh0_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .v({xa, 32'd0}),
    .done(sq_done), .root(sq_root)
  );

  assign op_done = mul_done | div_done | sq_done;
  assign issue   = !launched;
  assign busy    = (state != ST_IDLE);

  // Taylor divisors (2k)(2k+1) for sine and (2k-1)(2k) for cosine.
  assign tk      = {k[3:0], 1'b0};
  assign sin_div = 10'(tk) * 10'(tk + 5'd1);
  assign cos_div = 10'(tk - 5'd1) * 10'(tk);

  assign km_sum  = 33'(xa) + (33'd1 << 20);
  assign km_raw  = km_sum[32:21];

  // Early stop: |term| below 1e-12 of |sum|, from the upper product word.
  assign term_small = mag64(r) < mul_hi;

  // Angle x - pi/4 offset by half a quadrant; the quadrant count comes from
  // a multiplication by 2/pi and is then corrected by one step either way.
  assign ang_off = x - QUARTER_PI_Q40 + HALF_PI_HALF_Q40;
  assign ang_rem = ang_off - q40_t'(mul_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  // Next state and operand selection for the shared units.
  always_comb begin
    state_next = state;
    is_op      = 1'b1;
    mul_req    = '0;
    div_req    = '0;
    sq_start   = 1'b0;
    mul_a      = r;
    mul_b      = u;
    div_n      = 64'(x);
    div_d      = 64'(x);
    case (state)
      ST_IDLE: begin
        is_op = 1'b0;
        if (start) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        is_op = 1'b0;
        state_next = (xa <= X_SERIES_MAX) ? ST_SER_U : ST_ASY_KM;
      end
      // Power series: r <- -r * (x/(2k+1))^2.
      ST_SER_U: begin
        div_req.start = issue;
        div_d = 64'({k, 1'b1});
        if (op_done) state_next = ST_SER_RU;
      end
      ST_SER_RU: begin
        mul_req.start = issue;
        if (op_done) state_next = ST_SER_RUU;
      end
      ST_SER_RUU: begin
        mul_req.start = issue;
        mul_a = tmp;
        if (op_done) state_next = ST_SER_CHK;
      end
      ST_SER_CHK: begin
        mul_req.start = issue;
        mul_req.raw   = 1'b1;
        mul_a = s;
        mul_b = EPS_Q64;
        if (op_done) begin
          state_next = (term_small || k == KW'(MAX_SERIES_TERMS)) ? ST_SER_H1 : ST_SER_U;
        end
      end
      ST_SER_H1: begin
        mul_req.start = issue;
        mul_a = x;
        mul_b = TWO_OVER_PI_Q40;
        if (op_done) state_next = ST_SER_H2;
      end
      ST_SER_H2: begin
        mul_req.start = issue;
        mul_a = tmp;
        mul_b = s;
        if (op_done) state_next = ST_FIN;
      end
      // Asymptotic series: r <- -r * ((2k-1)/x)^2.
      ST_ASY_KM: begin
        is_op = 1'b0;
        state_next = ST_ASY_V;
      end
      ST_ASY_V: begin
        div_req.start = issue;
        div_req.frac  = 1'b1;
        div_n = 64'({k, 1'b0} - (KW + 1)'(1)) << 40;
        if (op_done) state_next = ST_ASY_VV;
      end
      ST_ASY_VV: begin
        mul_req.start = issue;
        mul_a = u;
        if (op_done) state_next = ST_ASY_R;
      end
      ST_ASY_R: begin
        mul_req.start = issue;
        mul_b = tmp;
        if (op_done) state_next = ST_ASY_CHK;
      end
      ST_ASY_CHK: begin
        mul_req.start = issue;
        mul_req.raw   = 1'b1;
        mul_a = s;
        mul_b = EPS_Q64;
        if (op_done) begin
          state_next = (term_small || k == km) ? ST_ASY_T : ST_ASY_V;
        end
      end
      // Y0 term: polynomials in t = 4/x.
      ST_ASY_T: begin
        div_req.start = issue;
        div_req.frac  = 1'b1;
        div_n = 64'd4 << 40;
        if (op_done) state_next = ST_ASY_T2;
      end
      ST_ASY_T2: begin
        mul_req.start = issue;
        mul_a = t;
        mul_b = t;
        if (op_done) state_next = ST_ASY_P;
      end
      ST_ASY_P: begin
        mul_req.start = issue;
        mul_a = p;
        mul_b = t2;
        if (op_done && ci == 3'd4) state_next = ST_ASY_Q;
      end
      ST_ASY_Q: begin
        mul_req.start = issue;
        mul_a = q;
        mul_b = t2;
        if (op_done && ci == 3'd4) state_next = ST_ASY_QT;
      end
      ST_ASY_QT: begin
        mul_req.start = issue;
        mul_a = q;
        mul_b = t;
        if (op_done) state_next = ST_ASY_N;
      end
      // Angle reduction of x - pi/4 by the nearest multiple of pi/2.
      ST_ASY_N: begin
        mul_req.start = issue;
        mul_req.raw   = 1'b1;
        mul_a = ang_off;
        mul_b = TWO_OVER_PI_Q40;
        if (op_done) state_next = ST_ASY_NH;
      end
      ST_ASY_NH: begin
        mul_req.start = issue;
        mul_req.raw   = 1'b1;
        mul_a = tmp;
        mul_b = HALF_PI_Q40;
        if (op_done) state_next = ST_ASY_R2;
      end
      ST_ASY_R2: begin
        mul_req.start = issue;
        mul_a = ang;
        mul_b = ang;
        if (op_done) state_next = ST_SIN_M;
      end
      ST_SIN_M: begin
        mul_req.start = issue;
        mul_a = term;
        mul_b = t2;
        if (op_done) state_next = ST_SIN_D;
      end
      ST_SIN_D: begin
        div_req.start = issue;
        div_n = mag64(tmp);
        div_d = 64'(sin_div);
        if (op_done) state_next = (k == KW'(8)) ? ST_COS_M : ST_SIN_M;
      end
      ST_COS_M: begin
        mul_req.start = issue;
        mul_a = term;
        mul_b = t2;
        if (op_done) state_next = ST_COS_D;
      end
      ST_COS_D: begin
        div_req.start = issue;
        div_n = mag64(tmp);
        div_d = 64'(cos_div);
        if (op_done) state_next = (k == KW'(8)) ? ST_ASY_QUAD : ST_COS_M;
      end
      ST_ASY_QUAD: begin
        is_op = 1'b0;
        state_next = ST_ASY_SQ;
      end
      ST_ASY_SQ: begin
        sq_start = issue;
        if (op_done) state_next = ST_ASY_W;
      end
      ST_ASY_W: begin
        div_req.start = issue;
        div_req.frac  = 1'b1;
        div_n = 64'd2 << 40;
        div_d = 64'(rt);
        if (op_done) state_next = ST_ASY_PS;
      end
      ST_ASY_PS: begin
        mul_req.start = issue;
        mul_a = p;
        mul_b = sn;
        if (op_done) state_next = ST_ASY_QC;
      end
      ST_ASY_QC: begin
        mul_req.start = issue;
        mul_a = q;
        mul_b = cs;
        if (op_done) state_next = ST_ASY_BY;
      end
      ST_ASY_BY: begin
        mul_req.start = issue;
        mul_a = w;
        mul_b = acc2;
        if (op_done) state_next = ST_ASY_G;
      end
      ST_ASY_G: begin
        div_req.start = issue;
        div_req.frac  = 1'b1;
        div_n = 64'(TWO_OVER_PI_Q40);
        if (op_done) state_next = ST_ASY_H;
      end
      ST_ASY_H: begin
        mul_req.start = issue;
        mul_a = tmp;
        mul_b = s;
        if (op_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        is_op = 1'b0;
        state_next = ST_IDLE;
      end
      default: begin
        is_op = 1'b0;
        state_next = ST_IDLE;
      end
    endcase
    launched_next = is_op && !op_done;
  end

  // Final Q40 -> Q30 rounding and saturation.
  logic [64:0] out_sum;
  logic [54:0] out_m;
  logic        out_neg;
  logic [31:0] out_val;

  always_comb begin
    out_sum = {1'b0, mag64(sh)} + 65'd512;
    out_m   = out_sum[64:10];
    out_neg = sh[63] ^ neg;
    if (out_neg) begin
      out_val = (out_m > 55'h8000_0000) ? 32'h8000_0000 : -out_m[31:0];
    end else begin
      out_val = (out_m > 55'h7FFF_FFFF) ? 32'h7FFF_FFFF : out_m[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FIN);
    end
  end

  // Datapath captures; in the arithmetic states each happens when the active unit reports done.
  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      h0_value <= out_val;
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          neg <= x_arg[31];
          xa  <= x_arg[31] ? -x_arg : x_arg;
          x   <= q40_t'({12'd0, (x_arg[31] ? -x_arg : x_arg), 20'd0});
          s   <= ONE_Q40;
          r   <= ONE_Q40;
          k   <= KW'(1);
        end
      end
      ST_SER_U: if (op_done) u <= div_q;
      ST_SER_RU: if (op_done) tmp <= mul_res;
      ST_SER_RUU: begin
        if (op_done) begin
          r <= -mul_res;
          s <= sat_add(s, -mul_res);
        end
      end
      ST_SER_CHK: if (op_done) k <= k + KW'(1);
      ST_SER_H1: if (op_done) tmp <= mul_res;
      ST_SER_H2: if (op_done) sh <= mul_res;
      ST_ASY_KM: begin
        if (xa >= X_ASYM_CAP || km_raw > 12'(MAX_ASYMPTOTIC_TERMS)) begin
          km <= KW'(MAX_ASYMPTOTIC_TERMS);
        end else begin
          km <= km_raw[KW-1:0];
        end
      end
      ST_ASY_V: if (op_done) u <= div_q;
      ST_ASY_VV: if (op_done) tmp <= mul_res;
      ST_ASY_R: begin
        if (op_done) begin
          r <= -mul_res;
          s <= sat_add(s, -mul_res);
        end
      end
      ST_ASY_CHK: if (op_done) k <= k + KW'(1);
      ST_ASY_T: if (op_done) t <= div_q;
      ST_ASY_T2: begin
        if (op_done) begin
          t2 <= mul_res;
          p  <= P_COEF[0];
          ci <= 3'd0;
        end
      end
      ST_ASY_P: begin
        if (op_done) begin
          p  <= mul_res + P_COEF[ci + 3'd1];
          ci <= ci + 3'd1;
          if (ci == 3'd4) begin
            q  <= Q_COEF[0];
            ci <= 3'd0;
          end
        end
      end
      ST_ASY_Q: begin
        if (op_done) begin
          q  <= mul_res + Q_COEF[ci + 3'd1];
          ci <= ci + 3'd1;
        end
      end
      ST_ASY_QT: if (op_done) q <= mul_res;
      // The upper 48 bits of the Q80 product are the estimated quadrant count.
      ST_ASY_N: if (op_done) tmp <= q40_t'(mul_hi >> 16);
      ST_ASY_NH: begin
        if (op_done) begin
          if (ang_rem[63]) begin
            nq  <= tmp[1:0] - 2'd1;
            ang <= ang_rem + HALF_PI_Q40 - HALF_PI_HALF_Q40;
          end else if (ang_rem >= HALF_PI_Q40) begin
            nq  <= tmp[1:0] + 2'd1;
            ang <= ang_rem - HALF_PI_Q40 - HALF_PI_HALF_Q40;
          end else begin
            nq  <= tmp[1:0];
            ang <= ang_rem - HALF_PI_HALF_Q40;
          end
        end
      end
      ST_ASY_R2: begin
        if (op_done) begin
          t2   <= mul_res;
          term <= ang;
          sn   <= ang;
          k    <= KW'(1);
        end
      end
      ST_SIN_M: if (op_done) tmp <= mul_res;
      ST_SIN_D: begin
        if (op_done) begin
          term <= tmp[63] ? div_q : -div_q;
          sn   <= sn + (tmp[63] ? div_q : -div_q);
          k    <= k + KW'(1);
          if (k == KW'(8)) begin
            term <= ONE_Q40;
            cs   <= ONE_Q40;
            k    <= KW'(1);
          end
        end
      end
      ST_COS_M: if (op_done) tmp <= mul_res;
      ST_COS_D: begin
        if (op_done) begin
          term <= tmp[63] ? div_q : -div_q;
          cs   <= cs + (tmp[63] ? div_q : -div_q);
          k    <= k + KW'(1);
        end
      end
      ST_ASY_QUAD: begin
        case (nq)
          2'd0: begin
            sn <= sn;
            cs <= cs;
          end
          2'd1: begin
            sn <= cs;
            cs <= -sn;
          end
          2'd2: begin
            sn <= -sn;
            cs <= -cs;
          end
          default: begin
            sn <= -cs;
            cs <= sn;
          end
        endcase
      end
      ST_ASY_SQ: if (op_done) rt <= q40_t'(sq_root << 14);
      ST_ASY_W: if (op_done) w <= div_q;
      ST_ASY_PS: if (op_done) tmp <= mul_res;
      ST_ASY_QC: if (op_done) acc2 <= sat_add(tmp, mul_res);
      ST_ASY_BY: if (op_done) by0 <= mul_res;
      ST_ASY_G: if (op_done) tmp <= div_q;
      ST_ASY_H: if (op_done) sh <= sat_add(mul_res, by0);
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sh0_checker.sv
// ---------------------------------------------------------------------------
// sh0_checker: port-level checks for the Struve H0 unit
// Watches the command and result ports over time; bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sh0_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A completed transaction is reported only once the unit is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done shown while busy");

  // An accepted command makes the unit busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // Reset leaves the unit idle with no result pending.
  a_reset_clear: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("unit not idle after reset");

endmodule

bind struve_h0_function_unit sh0_checker u_sh0_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);

`default_nettype wire
